// ===== design/sdri_pkg.sv =====
package sdri_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_BYTES_DEF = 8;
    localparam int INDEX_W       = 10;
    localparam int DATA_W        = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_KEY,
        ST_CMP,
        ST_FKEY,
        ST_FCHK,
        ST_INS,
        ST_SHR,
        ST_SHW
    } t_state;

endpackage

// ===== design/sdri_ram.sv =====
module sdri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/sorted_dedup_record_insert_top.sv =====
// Each transaction takes one record and returns one result, marked by
// o_result_valid for a single cycle; busy is high until that result is out.
// The receiver cannot stall: the result must be taken in the cycle in which
// o_result_valid is high. Each step of the binary search over the sorted
// order passes through ST_SRCH, ST_KEY and ST_CMP. The search is followed by
// a check of the candidate in ST_FKEY and ST_FCHK, or goes straight on to
// ST_INS when it ends past the last stored key. A merge ends after the check.
// An insertion stores the record in ST_INS and then moves every sorted entry
// above the new one up by one place, through ST_SHR and ST_SHW in turn,
// since the sorted-order memory is read and written one entry at a time.
module sorted_dedup_record_insert_top
    import sdri_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [63:0]        i_record_key,
    input  logic [DATA_W-1:0]  i_group_order,
    input  logic [DATA_W-1:0]  i_decomp_count,
    output logic               o_result_valid,
    output logic [INDEX_W-1:0] o_record_index,
    output logic               o_found,
    output logic               o_table_full,
    output logic               o_group_mismatch
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = 8 * KEY_BYTES;

    t_state r_state, n_state;
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_lo, n_lo, r_hi, n_hi, r_i, n_i;
    logic [IW-1:0]     r_slot, n_slot;
    logic [KW-1:0]     r_key;
    logic [DATA_W-1:0] r_grp, r_cnt;
    logic              r_valid, n_valid;
    logic [INDEX_W-1:0] r_index, n_index;
    logic              r_found, n_found, r_full, n_full, r_mis, n_mis;

    logic [CW-1:0]     mid;
    logic [DATA_W:0]   sum;

    logic              key_we, grp_we, cnt_we, ord_we;
    logic [IW-1:0]     key_waddr, cnt_waddr, ord_waddr;
    logic [IW-1:0]     key_raddr, grp_raddr, cnt_raddr, ord_raddr;
    logic [KW-1:0]     key_rd;
    logic [DATA_W-1:0] grp_rd, cnt_rd, cnt_wdata;
    logic [IW-1:0]     ord_rd, ord_wdata;

    sdri_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(r_key),
        .i_raddr(key_raddr), .o_rdata(key_rd)
    );

    sdri_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_grp (
        .i_clk(i_clk), .i_we(grp_we), .i_waddr(key_waddr), .i_wdata(r_grp),
        .i_raddr(grp_raddr), .o_rdata(grp_rd)
    );

    sdri_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr), .o_rdata(cnt_rd)
    );

    sdri_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr), .i_wdata(ord_wdata),
        .i_raddr(ord_raddr), .o_rdata(ord_rd)
    );

    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    assign sum = {1'b0, cnt_rd} + {1'b0, r_cnt};
    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_slot  <= n_slot;
        r_index <= n_index;
        r_found <= n_found;
        r_full  <= n_full;
        r_mis   <= n_mis;
        if (start && !busy) begin
            r_key <= i_record_key[KW-1:0];
            r_grp <= i_group_order;
            r_cnt <= i_decomp_count;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_total   = r_total;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_i       = r_i;
        n_slot    = r_slot;
        n_valid   = 1'b0;
        n_index   = r_index;
        n_found   = r_found;
        n_full    = r_full;
        n_mis     = r_mis;
        key_we    = 1'b0;
        grp_we    = 1'b0;
        cnt_we    = 1'b0;
        ord_we    = 1'b0;
        key_waddr = r_total[IW-1:0];
        cnt_waddr = r_total[IW-1:0];
        cnt_wdata = r_cnt;
        ord_waddr = r_i[IW-1:0];
        ord_wdata = ord_rd;
        key_raddr = ord_rd;
        grp_raddr = ord_rd;
        cnt_raddr = ord_rd;
        ord_raddr = mid[IW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_lo    = '0;
                    n_hi    = r_total;
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    ord_raddr = mid[IW-1:0];
                    n_state   = ST_KEY;
                end else if (r_lo < r_total) begin
                    ord_raddr = r_lo[IW-1:0];
                    n_state   = ST_FKEY;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_KEY: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (key_rd < r_key) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = ST_SRCH;
            end
            ST_FKEY: begin
                n_slot  = ord_rd;
                n_state = ST_FCHK;
            end
            ST_FCHK: begin
                if (key_rd == r_key) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = r_slot;
                    cnt_wdata = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
                    n_valid   = 1'b1;
                    n_index   = INDEX_W'(r_slot);
                    n_found   = 1'b1;
                    n_full    = 1'b0;
                    n_mis     = (grp_rd != r_grp);
                    n_state   = ST_IDLE;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                if (r_total >= CW'(CAPACITY)) begin
                    n_valid = 1'b1;
                    n_index = '0;
                    n_found = 1'b0;
                    n_full  = 1'b1;
                    n_mis   = 1'b0;
                    n_state = ST_IDLE;
                end else begin
                    key_we  = 1'b1;
                    grp_we  = 1'b1;
                    cnt_we  = 1'b1;
                    n_i     = r_total;
                    n_state = ST_SHR;
                end
            end
            ST_SHR: begin
                if (r_i > r_lo) begin
                    ord_raddr = IW'(r_i - CW'(1));
                    n_state   = ST_SHW;
                end else begin
                    ord_we    = 1'b1;
                    ord_waddr = r_lo[IW-1:0];
                    ord_wdata = r_total[IW-1:0];
                    n_total   = r_total + CW'(1);
                    n_valid   = 1'b1;
                    n_index   = INDEX_W'(r_total);
                    n_found   = 1'b0;
                    n_full    = 1'b0;
                    n_mis     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            ST_SHW: begin
                ord_we    = 1'b1;
                ord_waddr = r_i[IW-1:0];
                ord_wdata = ord_rd;
                n_i       = r_i - CW'(1);
                n_state   = ST_SHR;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_result_valid   = r_valid;
    assign o_record_index   = r_index;
    assign o_found          = r_found;
    assign o_table_full     = r_full;
    assign o_group_mismatch = r_mis;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import sdri_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               found;
        logic               full;
        logic               mismatch;
    } t_insert_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [63:0]        i_record_key;
    logic [DATA_W-1:0]  i_group_order;
    logic [DATA_W-1:0]  i_decomp_count;
    logic               o_result_valid;
    logic [INDEX_W-1:0] o_record_index;
    logic               o_found;
    logic               o_table_full;
    logic               o_group_mismatch;

    sorted_dedup_record_insert_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_record_key     (i_record_key),
        .i_group_order    (i_group_order),
        .i_decomp_count   (i_decomp_count),
        .o_result_valid   (o_result_valid),
        .o_record_index   (o_record_index),
        .o_found          (o_found),
        .o_table_full     (o_table_full),
        .o_group_mismatch (o_group_mismatch)
    );

    logic [63:0]       model_keys [CAP];
    logic [DATA_W-1:0] model_groups [CAP];
    logic [DATA_W-1:0] model_counts [CAP];
    int                model_sorted [CAP];
    int                model_total;

    t_insert_result pending_results [$];
    int             mismatch_count;
    int             idle_pct;
    int             watchdog;
    logic           timed_out;
    logic [63:0]    used_keys [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_insert_result predict_insert(logic [63:0] key,
                                                      logic [DATA_W-1:0] grp,
                                                      logic [DATA_W-1:0] cnt);
        t_insert_result r;
        int lo;
        int hi;
        int mid;
        int slot;
        logic [DATA_W:0] sum;
        lo = 0;
        hi = model_total;
        r = '0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (model_keys[model_sorted[mid]] < key) lo = mid + 1;
            else hi = mid;
        end
        if (lo < model_total && model_keys[model_sorted[lo]] == key) begin
            slot = model_sorted[lo];
            sum = {1'b0, model_counts[slot]} + {1'b0, cnt};
            model_counts[slot] = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
            r.index = slot[INDEX_W-1:0];
            r.found = 1'b1;
            r.mismatch = (model_groups[slot] != grp);
        end else if (model_total >= CAP) begin
            r.full = 1'b1;
        end else begin
            slot = model_total;
            model_keys[slot] = key;
            model_groups[slot] = grp;
            model_counts[slot] = cnt;
            for (int i = model_total; i > lo; i--) model_sorted[i] = model_sorted[i - 1];
            model_sorted[lo] = slot;
            model_total++;
            r.index = slot[INDEX_W-1:0];
        end
        return r;
    endfunction

    task automatic send_record(logic [63:0] key, logic [DATA_W-1:0] grp,
                               logic [DATA_W-1:0] cnt);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_record_key <= key;
        i_group_order <= grp;
        i_decomp_count <= cnt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_insert(key, grp, cnt));
        used_keys.push_back(key);
    endtask

    always @(posedge i_clk) begin
        t_insert_result exp_r;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result index %0d", o_record_index);
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r != {o_record_index, o_found, o_table_full, o_group_mismatch}) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp idx %0d f %b full %b gm %b, got idx %0d f %b full %b gm %b",
                                 exp_r.index, exp_r.found, exp_r.full, exp_r.mismatch,
                                 o_record_index, o_found, o_table_full, o_group_mismatch);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_result_valid || (start && !busy)) watchdog <= 0;
        else watchdog <= watchdog + 1;
    end

    always @(posedge i_clk) begin
        if (watchdog >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("[sorted_dedup_record_insert_top] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_used_key();
        if (used_keys.size() == 0) return rand_key();
        return used_keys[$urandom_range(used_keys.size() - 1)];
    endfunction

    task automatic test_directed();
        send_record(64'h0, 32'h0, 32'h0);
        send_record('1, '1, '1);
        send_record(64'h8000_0000_0000_0000, 32'h1, 32'h1);
        send_record(64'h0000_0000_0000_0001, 32'h5, 32'h7);
        send_record('1, '1, 32'h1);
        send_record('1, 32'h0, 32'hFFFF_FFFF);
        send_record(64'h0, 32'h0, 32'hFFFF_FFFF);
        send_record(64'h0, 32'h0, 32'h2);
        send_record(64'h8000_0000_0000_0000, 32'h2, 32'h0);
        send_record(64'h7FFF_FFFF_FFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA);
        send_record(64'h5555_5555_5555_5555, 32'h8000_0000, 32'h8000_0000);
        send_record(64'hAAAA_AAAA_AAAA_AAAA, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_record(64'h7FFF_FFFF_FFFF_FFFF, 32'hAAAA_5555, 32'h1);
    endtask

    task automatic test_random(int n, int reuse_pct);
        logic [63:0] k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < reuse_pct) k = pick_used_key();
            else if ($urandom_range(3) == 0) k = {56'h0, 8'($urandom())};
            else k = rand_key();
            send_record(k, ($urandom_range(3) == 0) ? 32'($urandom()) : 32'($urandom_range(3)),
                        ($urandom_range(7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15)
                                                 : 32'($urandom()));
        end
    endtask

    task automatic test_fill_table();
        idle_pct = 0;
        while (model_total < CAP) send_record(rand_key(), 32'($urandom()), 32'($urandom()));
        for (int i = 0; i < 20; i++) send_record(rand_key(), 32'($urandom()), 32'($urandom()));
        for (int i = 0; i < 20; i++) send_record(pick_used_key(), 32'($urandom()), 32'($urandom()));
    endtask

    initial begin
        int drain;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_record_key = '0;
        i_group_order = '0;
        i_decomp_count = '0;
        mismatch_count = 0;
        idle_pct = 0;
        watchdog = 0;
        timed_out = 1'b0;
        model_total = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100, 30);
        idle_pct = 64;
        test_random(100, 40);
        idle_pct = 25;
        test_random(100, 40);
        idle_pct = 0;
        test_random(80, 50);
        test_fill_table();
        start <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[sorted_dedup_record_insert_top] OK");
        else
            $display("[sorted_dedup_record_insert_top] ERROR");
        $finish;
    end
endmodule

// ===== sorted_dedup_record_insert_top.f =====
design/sdri_pkg.sv
design/sdri_ram.sv
design/sorted_dedup_record_insert_top.sv
test/tb_top.sv
